// File: src/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// shared constants, types and functions for the euler to quaternion block
// ----------------------------------------------------------------------------
package e2q_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int OUT_BITS      = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int RUN_STAGES    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
   localparam int CS_BITS       = 23;   // q2.20 with margin
   localparam int PAIR_BITS     = 2 * CS_BITS;
   localparam int TRIPLE_BITS   = 3 * CS_BITS;
   localparam int SUM_BITS      = TRIPLE_BITS + 1;

   localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [OUT_BITS-1:0] Q14_ONE = 16'sd16384;

   typedef logic signed [33:0] cord_type;

   typedef struct packed {
      logic signed [CS_BITS-1:0] c;
      logic signed [CS_BITS-1:0] s;
   } cs_type;

   function automatic logic signed [33:0] atan_turn32(input int i);
      logic signed [33:0] r;
      case (i)
         0:  r = 34'sd536870912;
         1:  r = 34'sd316933406;
         2:  r = 34'sd167458907;
         3:  r = 34'sd85004756;
         4:  r = 34'sd42667331;
         5:  r = 34'sd21354465;
         6:  r = 34'sd10679838;
         7:  r = 34'sd5340245;
         8:  r = 34'sd2670163;
         9:  r = 34'sd1335087;
         10: r = 34'sd667544;
         11: r = 34'sd333772;
         12: r = 34'sd166886;
         13: r = 34'sd83443;
         14: r = 34'sd41722;
         15: r = 34'sd20861;
         16: r = 34'sd10430;
         17: r = 34'sd5215;
         18: r = 34'sd2608;
         19: r = 34'sd1304;
         20: r = 34'sd652;
         21: r = 34'sd326;
         22: r = 34'sd163;
         23: r = 34'sd81;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: src/e2q_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic
// pipelined cordic, one rotation per stage, three angles in parallel lanes
// ----------------------------------------------------------------------------
module e2q_cordic (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     in_valid,
   input  logic signed [e2q_pkg::ANGLE_BITS-1:0]    in_angle [3],
   output logic                                     out_valid,
   output e2q_pkg::cs_type                          out_cs [3]
);

   localparam int N = e2q_pkg::RUN_STAGES;

   e2q_pkg::cord_type x_ff [N+1][3];
   e2q_pkg::cord_type y_ff [N+1][3];
   e2q_pkg::cord_type z_ff [N+1][3];
   logic              v_ff [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= N; k++) v_ff[k] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int k = 0; k < N; k++) v_ff[k+1] <= v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            x_ff[0][l] <= e2q_pkg::INV_GAIN_Q30;
            y_ff[0][l] <= '0;
            z_ff[0][l] <= 34'(in_angle[l]) <<< (31 - e2q_pkg::ANGLE_BITS);
         end
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_stage
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int l = 0; l < 3; l++) begin
               if (!z_ff[g][l][33]) begin
                  x_ff[g+1][l] <= x_ff[g][l] - (y_ff[g][l] >>> g);
                  y_ff[g+1][l] <= y_ff[g][l] + (x_ff[g][l] >>> g);
                  z_ff[g+1][l] <= z_ff[g][l] - e2q_pkg::atan_turn32(g);
               end else begin
                  x_ff[g+1][l] <= x_ff[g][l] + (y_ff[g][l] >>> g);
                  y_ff[g+1][l] <= y_ff[g][l] - (x_ff[g][l] >>> g);
                  z_ff[g+1][l] <= z_ff[g][l] + e2q_pkg::atan_turn32(g);
               end
            end
         end
      end
   end

   e2q_pkg::cord_type xr [3];
   e2q_pkg::cord_type yr [3];
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         xr[l] = (x_ff[N][l] + 34'sd512) >>> 10;
         yr[l] = (y_ff[N][l] + 34'sd512) >>> 10;
         out_cs[l].c = xr[l][e2q_pkg::CS_BITS-1:0];
         out_cs[l].s = yr[l][e2q_pkg::CS_BITS-1:0];
      end
   end
   assign out_valid = v_ff[N];

endmodule

// File: src/e2q_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_combine
// zyx quaternion product: pair products, triple products, sum and saturate
// ----------------------------------------------------------------------------
module e2q_combine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  e2q_pkg::cs_type                       in_cs [3],
   output logic                                  out_valid,
   output logic signed [e2q_pkg::OUT_BITS-1:0]   out_q [4]
);

   localparam int PB = e2q_pkg::PAIR_BITS;
   localparam int TB = e2q_pkg::TRIPLE_BITS;
   localparam int SB = e2q_pkg::SUM_BITS;

   // lane 0 roll, 1 pitch, 2 yaw
   logic signed [PB-1:0] cycr_ff, cysr_ff, sycr_ff, sysr_ff;
   logic signed [e2q_pkg::CS_BITS-1:0] cp_ff, sp_ff;
   logic signed [TB-1:0] t_ff [8];
   logic signed [SB-1:0] s_ff [4];
   logic signed [e2q_pkg::OUT_BITS-1:0] q_ff [4];
   logic [3:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[2:0], in_valid};
   end

   logic signed [SB-1:0] rnd [4];
   always_comb begin
      for (int k = 0; k < 4; k++) rnd[k] = (s_ff[k] + (SB'(1) <<< 45)) >>> 46;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cycr_ff <= PB'(in_cs[2].c) * PB'(in_cs[0].c);
         cysr_ff <= PB'(in_cs[2].c) * PB'(in_cs[0].s);
         sycr_ff <= PB'(in_cs[2].s) * PB'(in_cs[0].c);
         sysr_ff <= PB'(in_cs[2].s) * PB'(in_cs[0].s);
         cp_ff   <= in_cs[1].c;
         sp_ff   <= in_cs[1].s;
         t_ff[0] <= TB'(cycr_ff) * TB'(cp_ff);
         t_ff[1] <= TB'(sysr_ff) * TB'(sp_ff);
         t_ff[2] <= TB'(cysr_ff) * TB'(cp_ff);
         t_ff[3] <= TB'(sycr_ff) * TB'(sp_ff);
         t_ff[4] <= TB'(cycr_ff) * TB'(sp_ff);
         t_ff[5] <= TB'(sysr_ff) * TB'(cp_ff);
         t_ff[6] <= TB'(sycr_ff) * TB'(cp_ff);
         t_ff[7] <= TB'(cysr_ff) * TB'(sp_ff);
         s_ff[0] <= SB'(t_ff[0]) + SB'(t_ff[1]);
         s_ff[1] <= SB'(t_ff[2]) - SB'(t_ff[3]);
         s_ff[2] <= SB'(t_ff[4]) + SB'(t_ff[5]);
         s_ff[3] <= SB'(t_ff[6]) - SB'(t_ff[7]);
         for (int k = 0; k < 4; k++) begin
            if (rnd[k] > SB'(e2q_pkg::Q14_ONE))
               q_ff[k] <= e2q_pkg::Q14_ONE;
            else if (rnd[k] < -SB'(e2q_pkg::Q14_ONE))
               q_ff[k] <= -e2q_pkg::Q14_ONE;
            else
               q_ff[k] <= rnd[k][e2q_pkg::OUT_BITS-1:0];
         end
      end
   end

   assign out_valid = v_ff[3];
   assign out_q = q_ff;

   a_sat_w: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_q[0] <= e2q_pkg::Q14_ONE && out_q[0] >= -e2q_pkg::Q14_ONE))
      else $error("quat_w out of range");
   a_sat_x: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_q[1] <= e2q_pkg::Q14_ONE && out_q[1] >= -e2q_pkg::Q14_ONE))
      else $error("quat_x out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("valid bits moved during stall");

endmodule

// File: src/euler_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion
// zyx euler angles to unit quaternion via pipelined half-angle cordic
// ----------------------------------------------------------------------------
// usage:
//   req channel carries roll, pitch and yaw binary angles (one turn per
//   full 16-bit range); rsp channel returns w, x, y, z in signed q1.14.
//   each transaction in gives exactly one transaction out, in order.
//   the pipeline has one input register, 16 cordic stages (one
//   rotation each) and 4 stages of products, sum and saturation.
//   throughput is one transaction per cycle; the whole pipeline moves
//   together, so it advances whenever the output stage is empty or
//   being taken.
//   when the receiver holds rsp_ready low, the pipeline freezes with
//   every stage intact; req_ready drops only while the output holds a
//   result that is not taken.
//   synchronous reset clears all valid bits; no state is kept between
//   transactions.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [e2q_pkg::ANGLE_BITS-1:0]  req_roll_angle,
   input  logic signed [e2q_pkg::ANGLE_BITS-1:0]  req_pitch_angle,
   input  logic signed [e2q_pkg::ANGLE_BITS-1:0]  req_yaw_angle,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [e2q_pkg::OUT_BITS-1:0]    rsp_quat_w,
   output logic signed [e2q_pkg::OUT_BITS-1:0]    rsp_quat_x,
   output logic signed [e2q_pkg::OUT_BITS-1:0]    rsp_quat_y,
   output logic signed [e2q_pkg::OUT_BITS-1:0]    rsp_quat_z
);

   logic adv;
   logic signed [e2q_pkg::ANGLE_BITS-1:0] ang [3];
   logic            cs_valid;
   e2q_pkg::cs_type cs [3];
   logic signed [e2q_pkg::OUT_BITS-1:0] q [4];

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign ang[0] = req_roll_angle;
   assign ang[1] = req_pitch_angle;
   assign ang[2] = req_yaw_angle;

   e2q_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_angle  (ang),
      .out_valid (cs_valid),
      .out_cs    (cs)
   );

   e2q_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cs_valid),
      .in_cs     (cs),
      .out_valid (rsp_valid),
      .out_q     (q)
   );

   assign rsp_quat_w = q[0];
   assign rsp_quat_x = q[1];
   assign rsp_quat_y = q[2];
   assign rsp_quat_z = q[3];

endmodule

// File: verif/euler_to_quaternion_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_tb
// self-checking bench for the euler angle to quaternion converter: directed
// angle extremes and quadrant points, then random triples with random gaps
// on both channels, a long receiver hold-off and a full drain pause; every
// response is checked field by field against an in-bench cordic predictor
// ----------------------------------------------------------------------------
module euler_to_quaternion_tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct {
      logic signed [15:0] w, x, y, z;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [e2q_pkg::ANGLE_BITS-1:0] req_roll_angle = '0;
   logic signed [e2q_pkg::ANGLE_BITS-1:0] req_pitch_angle = '0;
   logic signed [e2q_pkg::ANGLE_BITS-1:0] req_yaw_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [e2q_pkg::OUT_BITS-1:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   quat_type expected_quats[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit timed_out = 1'b0;
   int hold_cycles = 0;

   euler_to_quaternion uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint sar(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void half_cos_sin(logic signed [15:0] ang, output longint c,
                                        output longint s);
      longint z, x, y, dx, dy;
      longint atan_tab[24] = '{536870912, 316933406, 167458907, 85004756,
         42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
         333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652,
         326, 163, 81};
      z = longint'(ang) * (longint'(1) << (31 - e2q_pkg::ANGLE_BITS));
      x = 652032874;
      y = 0;
      for (int i = 0; i < e2q_pkg::CORDIC_STAGES && i < 24; i++) begin
         dx = sar(y, i);
         dy = sar(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      c = sar(x + 512, 10);
      s = sar(y + 512, 10);
   endfunction

   function automatic logic signed [15:0] round_sat_q14(longint sum);
      longint r;
      r = sar(sum + (longint'(1) << 45), 46);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   function automatic quat_type predict_quat(logic signed [15:0] roll,
                                             logic signed [15:0] pitch,
                                             logic signed [15:0] yaw);
      longint cr, sr, cp, sp, cy, sy;
      quat_type q;
      half_cos_sin(roll, cr, sr);
      half_cos_sin(pitch, cp, sp);
      half_cos_sin(yaw, cy, sy);
      q.w = round_sat_q14(cy * cr * cp + sy * sr * sp);
      q.x = round_sat_q14(cy * sr * cp - sy * cr * sp);
      q.y = round_sat_q14(cy * cr * sp + sy * sr * cp);
      q.z = round_sat_q14(sy * cr * cp - cy * sr * sp);
      return q;
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // sends one transaction and records its expected quaternion
   task automatic send_angles(logic signed [15:0] roll, logic signed [15:0] pitch,
                              logic signed [15:0] yaw, bit gaps = 1'b1);
      int gap;
      gap = gaps ? random_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_roll_angle <= roll;
      req_pitch_angle <= pitch;
      req_yaw_angle <= yaw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_quats.push_back(predict_quat(roll, pitch, yaw));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_quats.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls unless a long hold-off is in force
   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= (random_gap() == 0);
   end

   // response checker
   always @(posedge clock) begin
      quat_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_quats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected transaction at %0t", $realtime);
         end else begin
            e = expected_quats.pop_front();
            if (rsp_quat_w !== e.w || rsp_quat_x !== e.x || rsp_quat_y !== e.y ||
                rsp_quat_z !== e.z) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at %0t: expected w=%0d x=%0d y=%0d z=%0d,",
                           $realtime, e.w, e.x, e.y, e.z,
                           " got w=%0d x=%0d y=%0d z=%0d",
                           rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic test_extremes();
      logic signed [15:0] pts[8] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
         16'sh4000, 16'shc000, 16'sh2000, 16'sh0001};
      foreach (pts[i]) send_angles(pts[i], pts[(i + 3) % 8], pts[(i + 5) % 8]);
      send_angles(16'sh8000, 16'sh8000, 16'sh8000);
      send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_angles(16'sh5555, 16'shaaaa, 16'sh0f0f);
      send_angles(16'shaaaa, 16'sh5555, 16'shf0f0);
      wait_drained();
   endtask

   task automatic test_random(int count);
      repeat (count)
         send_angles($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            hold_cycles = 0;
            while (hold_cycles < 200) begin
               @(posedge clock);
               hold_cycles++;
            end
            hold_rsp = 1'b0;
         end
         repeat (60)
            send_angles($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), 1'b0);
      join
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_random(250);
      wait_drained();
      test_backpressure();
      test_random(230);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_quats.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
